/* sv/svpwm_pkg.sv */
package svpwm_pkg;

   // input format and its conversion to q.16
   localparam int IN_WIDTH = 16;
   localparam int IN_FRAC  = IN_WIDTH - 2;
   localparam int UP_SHIFT = (IN_FRAC < 16) ? 16 - IN_FRAC : 0;
   localparam int DN_SHIFT = (IN_FRAC > 16) ? IN_FRAC - 16 : 0;
   localparam int EXT_W    = IN_WIDTH + UP_SHIFT;

   // internal widths
   localparam int Q_W    = 18;   // q2.16 reference
   localparam int DUTY_W = 24;   // dwell times and duties
   localparam int OFFS_W = 26;   // rescaled duty
   localparam int MA_W   = 26;   // multiplier data operand
   localparam int MB_W   = 18;   // multiplier coefficient operand
   localparam int PROD_W = MA_W + MB_W;
   localparam int CMP_W  = 16;
   localparam int SEC_W  = 3;

   // q.16 coefficients
   localparam logic signed [MB_W-1:0] K_SQRT3 = 18'sd113515;
   localparam logic signed [MB_W-1:0] K_COS30 = 18'sd56754;
   localparam logic signed [MB_W-1:0] K_GAIN  = 18'sd37449;
   localparam logic signed [OFFS_W-1:0] K_OFFS = 26'sd6554;
   localparam logic signed [DUTY_W-1:0] K_BIAS = 24'sd14418;
   localparam logic signed [DUTY_W-1:0] Q_ONE  = 24'sd65536;
   localparam logic [CMP_W-1:0] PERIOD_RESET   = 16'd17000;

   typedef struct packed {
      logic signed [IN_WIDTH-1:0] v_alpha;
      logic signed [IN_WIDTH-1:0] v_beta;
   } svpwm_req_type;

   typedef struct packed {
      logic [CMP_W-1:0] cmp_a;
      logic [CMP_W-1:0] cmp_b;
      logic [CMP_W-1:0] cmp_c;
      logic [SEC_W-1:0] sector;
   } svpwm_rsp_type;

   // shared multiplier operations
   typedef enum logic [1:0] {
      MUL_SQRT3,
      MUL_COS30,
      MUL_GAIN,
      MUL_PERIOD
   } mul_op_type;

   typedef struct packed {
      mul_op_type                op;
      logic signed [Q_W-1:0]     alpha;
      logic signed [DUTY_W-1:0]  bias_duty;
      logic signed [OFFS_W-1:0]  offs;
      logic [CMP_W-1:0]          period;
   } mul_req_type;

   // reference to q.16, floor when the input has more fraction bits
   function automatic logic signed [Q_W-1:0] to_q16(input logic signed [IN_WIDTH-1:0] x);
      logic signed [EXT_W-1:0] ext;
      ext = EXT_W'(x);
      ext = ext <<< UP_SHIFT;
      ext = ext >>> DN_SHIFT;
      return Q_W'(ext);
   endfunction

   // sign sum to sector
   function automatic logic [SEC_W-1:0] sector_of_sum(input logic [2:0] sum);
      logic [SEC_W-1:0] sec;
      unique case (sum)
         3'd0: sec = 3'd2;
         3'd1: sec = 3'd3;
         3'd2: sec = 3'd1;
         3'd3: sec = 3'd0;
         3'd4: sec = 3'd0;
         3'd5: sec = 3'd4;
         3'd6: sec = 3'd6;
         3'd7: sec = 3'd5;
      endcase
      return sec;
   endfunction

endpackage

/* sv/svpwm_mul.sv */
module svpwm_mul (
   input  logic                                  clock,
   input  svpwm_pkg::mul_req_type                mul_req,
   output logic signed [svpwm_pkg::PROD_W-1:0]   prod
);

   logic signed [svpwm_pkg::MA_W-1:0]   op_a;
   logic signed [svpwm_pkg::MB_W-1:0]   op_b;
   logic signed [svpwm_pkg::PROD_W-1:0] prod_ff;

   // operand selection
   always_comb begin
      unique case (mul_req.op)
         svpwm_pkg::MUL_SQRT3: begin
            op_a = svpwm_pkg::MA_W'(mul_req.alpha);
            op_b = svpwm_pkg::K_SQRT3;
         end
         svpwm_pkg::MUL_COS30: begin
            op_a = svpwm_pkg::MA_W'(mul_req.alpha);
            op_b = svpwm_pkg::K_COS30;
         end
         svpwm_pkg::MUL_GAIN: begin
            op_a = svpwm_pkg::MA_W'(mul_req.bias_duty);
            op_b = svpwm_pkg::K_GAIN;
         end
         svpwm_pkg::MUL_PERIOD: begin
            op_a = svpwm_pkg::MA_W'(mul_req.offs);
            op_b = signed'({2'b00, mul_req.period});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // registered signed product
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

/* sv/svpwm_compare_generator.sv */
// space-vector pwm compare generator, seven-segment pattern
// req channel: one alpha/beta reference (q2.14) per transfer, valid/stall
// handshake; req_stall is high while an item is being worked on.
// rsp channel: three phase compare values (0..period) and the sector; a
// sector of 0 marks a boundary case and repeats the previous compare values.
// csr port: csr_wr_en writes csr_wr_data into the pwm period; write it only
// while no item is in flight.
// each item runs through a small sequencer around a single shared multiplier,
// used eight times per item that is not a boundary case; a new item is taken
// only when the block is back in idle.
// the result sits in an output register, so a new item is accepted while it
// waits; if the receiver keeps rsp_stall high, the next item finishes and
// then waits for that register before the block returns to idle.
// reset (synchronous, active high) clears the held compare values to zero,
// sets the period to 17000 and drops rsp_valid.
module svpwm_compare_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  svpwm_pkg::svpwm_req_type      req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output svpwm_pkg::svpwm_rsp_type      rsp_data,
   input  logic                          csr_wr_en,
   input  logic [svpwm_pkg::CMP_W-1:0]   csr_wr_data
);

   localparam int Q_W    = svpwm_pkg::Q_W;
   localparam int DUTY_W = svpwm_pkg::DUTY_W;
   localparam int OFFS_W = svpwm_pkg::OFFS_W;
   localparam int PROD_W = svpwm_pkg::PROD_W;
   localparam int CMP_W  = svpwm_pkg::CMP_W;
   localparam int SEC_W  = svpwm_pkg::SEC_W;
   localparam int TEST_W = PROD_W + 1;
   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(32768);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SLOPE,
      ST_SECTOR,
      ST_TIME,
      ST_HALF,
      ST_DUTY,
      ST_GAIN,
      ST_OFFS,
      ST_SCALE,
      ST_CLAMP,
      ST_DONE
   } state_type;

   state_type                   state_ff;
   logic [1:0]                  idx_ff;
   logic signed [Q_W-1:0]       al_ff;
   logic signed [Q_W-1:0]       be_ff;
   logic [SEC_W-1:0]            sec_ff;
   logic signed [DUTY_W-1:0]    t1_ff;
   logic signed [DUTY_W-1:0]    t2_ff;
   logic signed [DUTY_W-1:0]    h_ff;
   logic signed [DUTY_W-1:0]    bias_ff [3];
   logic signed [OFFS_W-1:0]    offs_ff;
   logic [CMP_W-1:0]            last_cmp_ff [3];
   logic [CMP_W-1:0]            period_ff;
   logic                        rsp_valid_ff;
   svpwm_pkg::svpwm_rsp_type    rsp_ff;

   svpwm_pkg::mul_req_type      mul_req;
   logic signed [PROD_W-1:0]    prod;

   logic signed [TEST_W-1:0]    be_hi;
   logic signed [TEST_W-1:0]    test_minus;
   logic signed [TEST_W-1:0]    test_plus;
   logic [2:0]                  sign_sum;
   logic [SEC_W-1:0]            sec_in;
   logic signed [DUTY_W-1:0]    ta;
   logic signed [DUTY_W-1:0]    tb;
   logic signed [DUTY_W-1:0]    be_w;
   logic signed [DUTY_W-1:0]    t1_in;
   logic signed [DUTY_W-1:0]    t2_in;
   logic signed [DUTY_W-1:0]    t0;
   logic signed [DUTY_W-1:0]    h_in;
   logic signed [DUTY_W-1:0]    h_t1;
   logic signed [DUTY_W-1:0]    h_t2;
   logic signed [DUTY_W-1:0]    h_t12;
   logic signed [DUTY_W-1:0]    da;
   logic signed [DUTY_W-1:0]    db;
   logic signed [DUTY_W-1:0]    dc;
   logic signed [OFFS_W-1:0]    offs_in;
   logic signed [PROD_W-1:0]    scaled;
   logic [CMP_W-1:0]            cmp_in;
   logic                        rsp_free;

   // shared multiplier
   always_comb begin
      mul_req.alpha     = al_ff;
      mul_req.bias_duty = bias_ff[idx_ff];
      mul_req.offs      = offs_ff;
      mul_req.period    = period_ff;
      unique case (state_ff)
         ST_SECTOR: mul_req.op = svpwm_pkg::MUL_COS30;
         ST_GAIN:   mul_req.op = svpwm_pkg::MUL_GAIN;
         ST_SCALE:  mul_req.op = svpwm_pkg::MUL_PERIOD;
         default:   mul_req.op = svpwm_pkg::MUL_SQRT3;
      endcase
   end

   svpwm_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   // exact sign tests against beta * 65536 and 1.7321 * alpha
   always_comb begin
      be_hi      = TEST_W'(be_ff) <<< 16;
      test_minus = be_hi - TEST_W'(prod);
      test_plus  = be_hi + TEST_W'(prod);
      sign_sum   = {!(be_ff > 0), !(test_minus > 0), !(test_plus > 0)};
      sec_in     = svpwm_pkg::sector_of_sum(sign_sum);
   end

   // dwell times
   always_comb begin
      ta   = DUTY_W'((prod + RND_HALF) >>> 16);
      be_w = DUTY_W'(be_ff);
      tb   = (be_w + DUTY_W'(1)) >>> 1;
      unique case (sec_ff)
         3'd1: begin
            t1_in = ta - tb;
            t2_in = be_w;
         end
         3'd2: begin
            t1_in = ta + tb;
            t2_in = tb - ta;
         end
         3'd3: begin
            t1_in = be_w;
            t2_in = -ta - tb;
         end
         3'd4: begin
            t1_in = tb - ta;
            t2_in = -be_w;
         end
         3'd5: begin
            t1_in = -ta - tb;
            t2_in = ta - tb;
         end
         default: begin
            t1_in = -be_w;
            t2_in = ta + tb;
         end
      endcase
   end

   // zero-vector half time and phase duties
   always_comb begin
      t0    = svpwm_pkg::Q_ONE - t1_ff - t2_ff;
      h_in  = (t0 + DUTY_W'(1)) >>> 1;
      h_t1  = h_ff + t1_ff;
      h_t2  = h_ff + t2_ff;
      h_t12 = h_t1 + t2_ff;
      unique case (sec_ff)
         3'd1: begin
            da = h_t12;
            db = h_t2;
            dc = h_ff;
         end
         3'd2: begin
            da = h_t1;
            db = h_t12;
            dc = h_ff;
         end
         3'd3: begin
            da = h_ff;
            db = h_t12;
            dc = h_t2;
         end
         3'd4: begin
            da = h_ff;
            db = h_t1;
            dc = h_t12;
         end
         3'd5: begin
            da = h_t2;
            db = h_ff;
            dc = h_t12;
         end
         default: begin
            da = h_t12;
            db = h_ff;
            dc = h_t1;
         end
      endcase
   end

   // rescale offset and compare saturation
   always_comb begin
      offs_in = svpwm_pkg::K_OFFS + OFFS_W'((prod + RND_HALF) >>> 16);
      scaled  = prod >>> 16;
      priority if (scaled < 0) begin
         cmp_in = '0;
      end else if (scaled > PROD_W'(period_ff)) begin
         cmp_in = period_ff;
      end else begin
         cmp_in = scaled[CMP_W-1:0];
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // sequencer, held state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= svpwm_pkg::PERIOD_RESET;
         for (int i = 0; i < 3; i++) begin
            last_cmp_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         // output register empties unless a new result is loaded this cycle
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  al_ff    <= svpwm_pkg::to_q16(req_data.v_alpha);
                  be_ff    <= svpwm_pkg::to_q16(req_data.v_beta);
                  state_ff <= ST_SLOPE;
               end
            end
            ST_SLOPE: begin
               state_ff <= ST_SECTOR;
            end
            ST_SECTOR: begin
               sec_ff <= sec_in;
               if (sec_in == '0) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_TIME;
               end
            end
            ST_TIME: begin
               t1_ff    <= t1_in;
               t2_ff    <= t2_in;
               state_ff <= ST_HALF;
            end
            ST_HALF: begin
               h_ff     <= h_in;
               state_ff <= ST_DUTY;
            end
            ST_DUTY: begin
               bias_ff[0] <= da + svpwm_pkg::K_BIAS;
               bias_ff[1] <= db + svpwm_pkg::K_BIAS;
               bias_ff[2] <= dc + svpwm_pkg::K_BIAS;
               idx_ff     <= '0;
               state_ff   <= ST_GAIN;
            end
            ST_GAIN: begin
               state_ff <= ST_OFFS;
            end
            ST_OFFS: begin
               offs_ff  <= offs_in;
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               state_ff <= ST_CLAMP;
            end
            ST_CLAMP: begin
               last_cmp_ff[idx_ff] <= cmp_in;
               if (idx_ff == 2'd2) begin
                  state_ff <= ST_DONE;
               end else begin
                  idx_ff   <= idx_ff + 2'd1;
                  state_ff <= ST_GAIN;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_ff.cmp_a <= last_cmp_ff[0];
                  rsp_ff.cmp_b <= last_cmp_ff[1];
                  rsp_ff.cmp_c <= last_cmp_ff[2];
                  rsp_ff.sector <= sec_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
